>>> hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/tmrhs_pkg.sv
// shared types, codes and hamming(7,4) helpers for the tmr scrub store
// no dependencies
`default_nettype none

package tmrhs_pkg;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_INJECT = 2'd2;
    localparam logic [1:0] MODE_SCRUB  = 2'd3;

    localparam logic [1:0] ST_AGREE    = 2'd0;
    localparam logic [1:0] ST_MAJORITY = 2'd1;
    localparam logic [1:0] ST_HAMMING  = 2'd2;
    localparam logic [1:0] ST_IGNORED  = 2'd3;

    localparam logic [1:0] SEL_NONE = 2'd3;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // one stored location: three copies and the code word of the low nibble
    typedef struct packed {
        logic [7:0] copy0;
        logic [7:0] copy1;
        logic [7:0] copy2;
        logic [6:0] parity;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic clear_step;
        logic exec;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
    } t_dp_stat;

    // bit 0 first: p1 p2 d1 p3 d2 d3 d4
    function automatic logic [6:0] ham_code(input logic [3:0] nib);
        logic p1, p2, p3;
        p1 = nib[0] ^ nib[1] ^ nib[3];
        p2 = nib[0] ^ nib[2] ^ nib[3];
        p3 = nib[1] ^ nib[2] ^ nib[3];
        return {nib[3], nib[2], nib[1], p3, nib[0], p2, p1};
    endfunction

    function automatic logic [3:0] ham_fix(input logic [6:0] w);
        logic [2:0] syn;
        logic [6:0] fixed;
        syn[0] = w[0] ^ w[2] ^ w[4] ^ w[6];
        syn[1] = w[1] ^ w[2] ^ w[5] ^ w[6];
        syn[2] = w[3] ^ w[4] ^ w[5] ^ w[6];
        fixed  = w;
        if (syn != 3'd0) begin
            fixed = w ^ (7'd1 << (syn - 3'd1));
        end
        return {fixed[6], fixed[5], fixed[4], fixed[2]};
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tmrhs_ctrl.sv
// sequencing fsm: clearing pass after reset, then read / execute per request
// depends on tmrhs_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tmrhs_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire tmrhs_pkg::t_dp_stat i_stat,
    output tmrhs_pkg::t_dp_cmd      o_cmd,
    output logic                    o_busy
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_EXEC  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_cmd.capture    = 1'b0;
        o_cmd.clear_step = 1'b0;
        o_cmd.exec       = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    `ASSERT_ALWAYS(a_cmd_exclusive, i_clk, i_rst_n,
        $onehot0({o_cmd.capture, o_cmd.clear_step, o_cmd.exec}))
    `ASSERT_IMPLY(a_exec_follows_capture, i_clk, i_rst_n,
        o_cmd.exec, $past(o_cmd.capture, 2))

endmodule

`default_nettype wire

>>> hw/rtl/tmrhs_datapath.sv
// protected store, vote and hamming recovery, counters and result registers
// depends on tmrhs_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tmrhs_datapath #(
    parameter int STORE_DEPTH = 4096
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tmrhs_pkg::t_dp_cmd  i_cmd,
    output tmrhs_pkg::t_dp_stat      o_stat,
    input  wire logic [1:0]          i_mode,
    input  wire logic [11:0]         i_address,
    input  wire logic [7:0]          i_write_data,
    input  wire logic [1:0]          i_copy_select,
    input  wire logic [2:0]          i_bit_index,
    output logic                     o_strobe,
    output logic [7:0]               o_read_data,
    output logic [1:0]               o_vote_status,
    output logic                     o_healed,
    output logic [15:0]              o_upset_total,
    output logic [15:0]              o_healed_total
);

    localparam int AW = $clog2(STORE_DEPTH);

    tmrhs_pkg::t_entry r_mem [STORE_DEPTH];
    tmrhs_pkg::t_entry r_rd;

    // captured request
    logic [1:0]    r_mode;
    logic [AW-1:0] r_idx;
    logic          r_ok;
    logic [7:0]    r_wdata;
    logic [1:0]    r_sel;
    logic [2:0]    r_bit;

    logic [AW-1:0] r_clr_idx;
    logic [15:0]   r_upset_cnt;
    logic [15:0]   n_upset_cnt;
    logic [15:0]   r_repair_cnt;
    logic [15:0]   n_repair_cnt;

    logic          r_strobe;
    logic [7:0]    r_read_data;
    logic [7:0]    n_read_data;
    logic [1:0]    r_status;
    logic [1:0]    n_status;
    logic          r_healed;
    logic          n_healed;

    logic               n_we;
    logic [AW-1:0]      n_waddr;
    tmrhs_pkg::t_entry  n_wentry;

    logic [7:0] vote_val;
    logic [1:0] vote_st;
    logic [7:0] flip_mask;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_idx   <= AW'(i_address);
            r_ok    <= (32'(i_address) < STORE_DEPTH);
            r_wdata <= i_write_data;
            r_sel   <= i_copy_select;
            r_bit   <= i_bit_index;
        end
    end

    // store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_waddr] <= n_wentry;
        end
        r_rd <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_idx <= r_clr_idx + AW'(1);
        end
    end

    assign o_stat.clear_last = (r_clr_idx == AW'(STORE_DEPTH - 1));

    // majority vote, hamming fallback on a three-way split
    always_comb begin
        if ((r_rd.copy0 == r_rd.copy1) && (r_rd.copy1 == r_rd.copy2)) begin
            vote_val = r_rd.copy0;
            vote_st  = tmrhs_pkg::ST_AGREE;
        end else if ((r_rd.copy0 == r_rd.copy1) || (r_rd.copy0 == r_rd.copy2)) begin
            vote_val = r_rd.copy0;
            vote_st  = tmrhs_pkg::ST_MAJORITY;
        end else if (r_rd.copy1 == r_rd.copy2) begin
            vote_val = r_rd.copy1;
            vote_st  = tmrhs_pkg::ST_MAJORITY;
        end else begin
            vote_val = {4'd0, tmrhs_pkg::ham_fix(r_rd.parity)};
            vote_st  = tmrhs_pkg::ST_HAMMING;
        end
    end

    assign flip_mask = 8'd1 << r_bit;

    always_comb begin
        n_we         = 1'b0;
        n_waddr      = r_idx;
        n_wentry     = r_rd;
        n_read_data  = 8'd0;
        n_status     = tmrhs_pkg::ST_AGREE;
        n_healed     = 1'b0;
        n_upset_cnt  = r_upset_cnt;
        n_repair_cnt = r_repair_cnt;
        if (i_cmd.clear_step) begin
            n_we     = 1'b1;
            n_waddr  = r_clr_idx;
            n_wentry = '0;
        end else if (i_cmd.exec) begin
            case (r_mode)
                tmrhs_pkg::MODE_WRITE: begin
                    n_we     = r_ok;
                    n_wentry = '{copy0: r_wdata, copy1: r_wdata, copy2: r_wdata,
                                 parity: tmrhs_pkg::ham_code(r_wdata[3:0])};
                end
                tmrhs_pkg::MODE_READ: begin
                    if (r_ok) begin
                        n_read_data = vote_val;
                        n_status    = vote_st;
                    end
                end
                tmrhs_pkg::MODE_INJECT: begin
                    if (!r_ok || (r_sel == tmrhs_pkg::SEL_NONE)) begin
                        n_status = tmrhs_pkg::ST_IGNORED;
                    end else begin
                        n_we = 1'b1;
                        case (r_sel)
                            2'd0:    n_wentry.copy0 = r_rd.copy0 ^ flip_mask;
                            2'd1:    n_wentry.copy1 = r_rd.copy1 ^ flip_mask;
                            default: n_wentry.copy2 = r_rd.copy2 ^ flip_mask;
                        endcase
                        if (r_upset_cnt != tmrhs_pkg::COUNT_MAX) begin
                            n_upset_cnt = r_upset_cnt + 16'd1;
                        end
                    end
                end
                tmrhs_pkg::MODE_SCRUB: begin
                    if (r_ok) begin
                        n_read_data = vote_val;
                        n_status    = vote_st;
                        if (vote_st != tmrhs_pkg::ST_AGREE) begin
                            // parity word is kept as stored
                            n_we           = 1'b1;
                            n_wentry.copy0 = vote_val;
                            n_wentry.copy1 = vote_val;
                            n_wentry.copy2 = vote_val;
                            n_healed       = 1'b1;
                            if (r_repair_cnt != tmrhs_pkg::COUNT_MAX) begin
                                n_repair_cnt = r_repair_cnt + 16'd1;
                            end
                        end
                    end
                end
                default: begin
                    n_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe     <= 1'b0;
            r_upset_cnt  <= 16'd0;
            r_repair_cnt <= 16'd0;
        end else begin
            r_strobe     <= i_cmd.exec;
            r_upset_cnt  <= n_upset_cnt;
            r_repair_cnt <= n_repair_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_read_data <= n_read_data;
            r_status    <= n_status;
            r_healed    <= n_healed;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_read_data    = r_read_data;
    assign o_vote_status  = r_status;
    assign o_healed       = r_healed;
    assign o_upset_total  = r_upset_cnt;
    assign o_healed_total = r_repair_cnt;

    `ASSERT_IMPLY(a_repair_needs_split, i_clk, i_rst_n,
        r_strobe && r_healed,
        (r_status == tmrhs_pkg::ST_MAJORITY) || (r_status == tmrhs_pkg::ST_HAMMING))
    `ASSERT_IMPLY(a_upset_monotonic, i_clk, i_rst_n,
        $past(i_rst_n), r_upset_cnt >= $past(r_upset_cnt))

endmodule

`default_nettype wire

>>> hw/rtl/tmr_memory_with_hamming_scrub_core.sv
// triple-copy byte store with hamming(7,4) backup of the low nibble
// a request runs in order through accept, registered store read, vote and write back
// o_strobe is registered from the vote and write back step; the receiver cannot stall
// busy stays high through the store read and the vote and write back, so requests do not overlap
// reset: synchronous; a clearing pass zeroes every store location with busy high
`default_nettype none

module tmr_memory_with_hamming_scrub_core #(
    parameter int STORE_DEPTH = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_mode,
    input  wire logic [11:0] i_address,
    input  wire logic [7:0]  i_write_data,
    input  wire logic [1:0]  i_copy_select,
    input  wire logic [2:0]  i_bit_index,
    output logic             o_strobe,
    output logic [7:0]       o_read_data,
    output logic [1:0]       o_vote_status,
    output logic             o_healed,
    output logic [15:0]      o_upset_total,
    output logic [15:0]      o_healed_total
);

    tmrhs_pkg::t_dp_cmd  dp_cmd;
    tmrhs_pkg::t_dp_stat dp_stat;

    tmrhs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    tmrhs_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_mode         (i_mode),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .i_copy_select  (i_copy_select),
        .i_bit_index    (i_bit_index),
        .o_strobe       (o_strobe),
        .o_read_data    (o_read_data),
        .o_vote_status  (o_vote_status),
        .o_healed       (o_healed),
        .o_upset_total  (o_upset_total),
        .o_healed_total (o_healed_total)
    );

endmodule

`default_nettype wire

>>> verif/tmr_memory_with_hamming_scrub_core_tb.sv
// self-checking testbench for the triple-copy byte store with hamming(7,4) backup
// depends on tmrhs_pkg and tmr_memory_with_hamming_scrub_core; runs directed,
// random and back to back requests against a scoreboard model of the store
`timescale 1ns / 100ps

module tmr_memory_with_hamming_scrub_core_tb;

    localparam int DEPTH = 4096;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int RANDOM_REQUESTS = 1000;
    localparam int BURST_ROUNDS = 40;

    typedef struct packed {
        logic [7:0]  data;
        logic [1:0]  status;
        logic        healed;
        logic [15:0] upsets;
        logic [15:0] heals;
    } t_answer;

    class store_scoreboard;
        logic [7:0]  copy_a [DEPTH];
        logic [7:0]  copy_b [DEPTH];
        logic [7:0]  copy_c [DEPTH];
        logic [6:0]  code [DEPTH];
        logic [15:0] upsets;
        logic [15:0] heals;
        t_answer     awaited [$];
        int          errors;

        function new();
            int i;
            for (i = 0; i < DEPTH; i++) begin
                copy_a[i] = '0;
                copy_b[i] = '0;
                copy_c[i] = '0;
                code[i]   = '0;
            end
            upsets = '0;
            heals  = '0;
            errors = 0;
        endfunction

        // xor of the 1-based positions of all set bits
        function logic [2:0] syndrome(logic [6:0] w);
            logic [2:0] s;
            int i;
            s = '0;
            for (i = 0; i < 7; i++) begin
                if (w[i]) s ^= 3'(i + 1);
            end
            return s;
        endfunction

        // place data at positions 3,5,6,7 then pick parity so the syndrome is zero
        function logic [6:0] encode(logic [3:0] nib);
            logic [6:0] w;
            logic [2:0] s;
            w = {nib[3], nib[2], nib[1], 1'b0, nib[0], 2'b00};
            s = syndrome(w);
            w[0] = s[0];
            w[1] = s[1];
            w[3] = s[2];
            return w;
        endfunction

        function logic [3:0] recover(logic [6:0] w);
            logic [2:0] s;
            s = syndrome(w);
            if (s != 3'd0) w[s - 3'd1] = ~w[s - 3'd1];
            return {w[6], w[5], w[4], w[2]};
        endfunction

        function logic [7:0] vote(logic [11:0] a, output logic [1:0] st);
            logic [7:0] x, y, z;
            x = copy_a[a];
            y = copy_b[a];
            z = copy_c[a];
            st = (x == y && y == z) ? tmrhs_pkg::ST_AGREE : tmrhs_pkg::ST_MAJORITY;
            if (x == y || x == z) return x;
            if (y == z) return y;
            st = tmrhs_pkg::ST_HAMMING;
            return {4'h0, recover(code[a])};
        endfunction

        function void note_request(logic [1:0] mode, logic [11:0] addr, logic [7:0] wdata,
                                   logic [1:0] sel, logic [2:0] bidx);
            t_answer ans;
            logic [7:0] v;
            logic [1:0] st;
            bit in_range;
            ans = '0;
            in_range = int'(addr) < DEPTH;
            case (mode)
                tmrhs_pkg::MODE_WRITE: begin
                    if (in_range) begin
                        copy_a[addr] = wdata;
                        copy_b[addr] = wdata;
                        copy_c[addr] = wdata;
                        code[addr]   = encode(wdata[3:0]);
                    end
                end
                tmrhs_pkg::MODE_READ: begin
                    if (in_range) begin
                        ans.data   = vote(addr, st);
                        ans.status = st;
                    end
                end
                tmrhs_pkg::MODE_INJECT: begin
                    if (!in_range || sel == tmrhs_pkg::SEL_NONE) begin
                        ans.status = tmrhs_pkg::ST_IGNORED;
                    end else begin
                        case (sel)
                            2'd0:    copy_a[addr][bidx] = ~copy_a[addr][bidx];
                            2'd1:    copy_b[addr][bidx] = ~copy_b[addr][bidx];
                            default: copy_c[addr][bidx] = ~copy_c[addr][bidx];
                        endcase
                        if (upsets != tmrhs_pkg::COUNT_MAX) upsets++;
                    end
                end
                default: begin
                    if (in_range) begin
                        v = vote(addr, st);
                        ans.data   = v;
                        ans.status = st;
                        if (st != tmrhs_pkg::ST_AGREE) begin
                            // hamming fallback leaves the code word alone
                            copy_a[addr] = v;
                            copy_b[addr] = v;
                            copy_c[addr] = v;
                            ans.healed = 1'b1;
                            if (heals != tmrhs_pkg::COUNT_MAX) heals++;
                        end
                    end
                end
            endcase
            ans.upsets = upsets;
            ans.heals  = heals;
            awaited.push_back(ans);
        endfunction

        function void complain(string what, int unsigned want, int unsigned got);
            errors++;
            if (errors <= 10) begin
                $display("%0t: %s expected %0d got %0d", $time, what, want, got);
            end
        endfunction

        function void check_result(t_answer got);
            t_answer want;
            if (awaited.size() == 0) begin
                complain("results pending", 0, 1);
                return;
            end
            want = awaited.pop_front();
            if (got.data !== want.data) complain("read_data", want.data, got.data);
            if (got.status !== want.status) complain("vote_status", want.status, got.status);
            if (got.healed !== want.healed) complain("healed", want.healed, got.healed);
            if (got.upsets !== want.upsets) complain("upset_total", want.upsets, got.upsets);
            if (got.heals !== want.heals) complain("healed_total", want.heals, got.heals);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_mode;
    logic [11:0] i_address;
    logic [7:0]  i_write_data;
    logic [1:0]  i_copy_select;
    logic [2:0]  i_bit_index;
    logic        o_strobe;
    logic [7:0]  o_read_data;
    logic [1:0]  o_vote_status;
    logic        o_healed;
    logic [15:0] o_upset_total;
    logic [15:0] o_healed_total;

    store_scoreboard sb;
    bit              idling;
    int              issued;
    int              cycles;
    logic [11:0]     hot_addr [16];

    tmr_memory_with_hamming_scrub_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .i_copy_select  (i_copy_select),
        .i_bit_index    (i_bit_index),
        .o_strobe       (o_strobe),
        .o_read_data    (o_read_data),
        .o_vote_status  (o_vote_status),
        .o_healed       (o_healed),
        .o_upset_total  (o_upset_total),
        .o_healed_total (o_healed_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL tmr_memory_with_hamming_scrub_core");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check_result('{o_read_data, o_vote_status, o_healed,
                              o_upset_total, o_healed_total});
        end
    end

    // start low with junk on the request fields
    task automatic hold_off(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start         <= 1'b0;
            i_mode        <= 2'($urandom);
            i_address     <= 12'($urandom);
            i_write_data  <= 8'($urandom);
            i_copy_select <= 2'($urandom);
            i_bit_index   <= 3'($urandom);
        end
    endtask

    task automatic send_request(input logic [1:0] mode, input logic [11:0] addr,
                                input logic [7:0] wdata, input logic [1:0] sel,
                                input logic [2:0] bidx);
        if (idling && $urandom_range(0, 3) == 0) hold_off(int'($urandom_range(1, 13)));
        @(negedge i_clk);
        start         <= 1'b1;
        i_mode        <= mode;
        i_address     <= addr;
        i_write_data  <= wdata;
        i_copy_select <= sel;
        i_bit_index   <= bidx;
        do @(posedge i_clk); while (busy);
        sb.note_request(mode, addr, wdata, sel, bidx);
        issued++;
    endtask

    function automatic logic [11:0] pick_address();
        if ($urandom_range(0, 3) == 0) return 12'($urandom);
        return hot_addr[$urandom_range(0, 15)];
    endfunction

    initial begin
        logic [11:0] a;
        int n, i;
        sb = new();
        cycles = 0;
        issued = 0;
        idling = 1'b1;
        start = 1'b0;
        i_rst_n = 1'b0;
        i_mode = tmrhs_pkg::MODE_WRITE;
        i_address = '0;
        i_write_data = '0;
        i_copy_select = '0;
        i_bit_index = '0;
        hot_addr[0] = 12'h000;
        hot_addr[1] = 12'hFFF;
        for (i = 2; i < 16; i++) hot_addr[i] = 12'($urandom);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every vote outcome and the ignored inject
        send_request(tmrhs_pkg::MODE_READ,   12'h000, 8'h00, 2'd0, 3'd0);
        send_request(tmrhs_pkg::MODE_WRITE,  12'h000, 8'h00, 2'd0, 3'd0);
        send_request(tmrhs_pkg::MODE_WRITE,  12'hFFF, 8'hFF, 2'd3, 3'd7);
        send_request(tmrhs_pkg::MODE_READ,   12'hFFF, 8'h00, 2'd0, 3'd0);
        send_request(tmrhs_pkg::MODE_READ,   12'h000, 8'hFF, 2'd3, 3'd7);
        send_request(tmrhs_pkg::MODE_WRITE,  12'h5A5, 8'hA5, 2'd0, 3'd0);
        send_request(tmrhs_pkg::MODE_INJECT, 12'h5A5, 8'h00, 2'd0, 3'd7);
        send_request(tmrhs_pkg::MODE_READ,   12'h5A5, 8'h00, 2'd0, 3'd0);
        send_request(tmrhs_pkg::MODE_SCRUB,  12'h5A5, 8'h00, 2'd0, 3'd0);
        send_request(tmrhs_pkg::MODE_READ,   12'h5A5, 8'h00, 2'd0, 3'd0);
        send_request(tmrhs_pkg::MODE_INJECT, 12'h5A5, 8'h00, 2'd1, 3'd0);
        send_request(tmrhs_pkg::MODE_READ,   12'h5A5, 8'h00, 2'd0, 3'd0);
        send_request(tmrhs_pkg::MODE_INJECT, 12'h5A5, 8'h00, 2'd1, 3'd0);
        send_request(tmrhs_pkg::MODE_INJECT, 12'h5A5, 8'h00, 2'd2, 3'd3);
        send_request(tmrhs_pkg::MODE_READ,   12'h5A5, 8'h00, 2'd0, 3'd0);
        send_request(tmrhs_pkg::MODE_SCRUB,  12'h5A5, 8'h00, 2'd0, 3'd0);
        // three-way mismatch falls back to the hamming word
        send_request(tmrhs_pkg::MODE_INJECT, 12'h5A5, 8'h00, 2'd0, 3'd1);
        send_request(tmrhs_pkg::MODE_INJECT, 12'h5A5, 8'h00, 2'd1, 3'd2);
        send_request(tmrhs_pkg::MODE_INJECT, 12'h5A5, 8'h00, 2'd2, 3'd6);
        send_request(tmrhs_pkg::MODE_READ,   12'h5A5, 8'h00, 2'd0, 3'd0);
        send_request(tmrhs_pkg::MODE_SCRUB,  12'h5A5, 8'h00, 2'd0, 3'd0);
        send_request(tmrhs_pkg::MODE_READ,   12'h5A5, 8'h00, 2'd0, 3'd0);
        send_request(tmrhs_pkg::MODE_INJECT, 12'h5A5, 8'h00, tmrhs_pkg::SEL_NONE, 3'd4);
        send_request(tmrhs_pkg::MODE_SCRUB,  12'h000, 8'h00, 2'd0, 3'd0);

        // random: mostly write, upsets, vote and readback on one location
        issued = 0;
        while (issued < RANDOM_REQUESTS) begin
            if ($urandom_range(0, 40) == 0) idling = !idling;
            if ($urandom_range(0, 9) < 7) begin
                a = pick_address();
                send_request(tmrhs_pkg::MODE_WRITE, a, 8'($urandom), 2'($urandom),
                             3'($urandom));
                n = int'($urandom_range(0, 4));
                repeat (n) begin
                    send_request(tmrhs_pkg::MODE_INJECT, a, 8'($urandom), 2'($urandom),
                                 3'($urandom));
                end
                send_request($urandom_range(0, 1) ? tmrhs_pkg::MODE_READ
                                                  : tmrhs_pkg::MODE_SCRUB,
                             a, 8'($urandom), 2'($urandom), 3'($urandom));
                send_request(tmrhs_pkg::MODE_READ, a, 8'($urandom), 2'($urandom),
                             3'($urandom));
            end else begin
                send_request(2'($urandom), pick_address(), 8'($urandom), 2'($urandom),
                             3'($urandom));
            end
        end

        // back to back: upsets and repairs on one location
        idling = 1'b0;
        a = hot_addr[$urandom_range(0, 15)];
        for (i = 0; i < BURST_ROUNDS; i++) begin
            send_request(tmrhs_pkg::MODE_INJECT, a, 8'($urandom), 2'($urandom_range(0, 2)),
                         3'($urandom));
            send_request(tmrhs_pkg::MODE_SCRUB, a, 8'($urandom), 2'($urandom),
                         3'($urandom));
        end
        send_request(tmrhs_pkg::MODE_READ, a, 8'h00, 2'd0, 3'd0);

        @(negedge i_clk);
        start <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("PASS tmr_memory_with_hamming_scrub_core");
        end else begin
            $display("FAIL tmr_memory_with_hamming_scrub_core");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/tmrhs_pkg.sv
hw/rtl/tmrhs_ctrl.sv
hw/rtl/tmrhs_datapath.sv
hw/rtl/tmr_memory_with_hamming_scrub_core.sv
verif/tmr_memory_with_hamming_scrub_core_tb.sv
